>>> rtl/rfc_pkg.sv
// shared types, constants and crc helper for the record framer
`default_nettype none

package rfc_pkg;

    // crc-16 ccitt-false constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // register index of the sync byte (selected by paddr[2])
    localparam logic REG_SYNC = 1'b0;

    // byte slots of one framed record
    typedef enum logic [4:0] {
        PH_SYNC   = 5'b00001,
        PH_TOPIC  = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_CRC_LO = 5'b01000,
        PH_CRC_HI = 5'b10000
    } t_phase_e;

    // configuration seen by the framing datapath
    typedef struct packed {
        logic [7:0] sync_byte;
    } t_cfg;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_push(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rfc_apb.sv
// apb register block holding the sync byte
`default_nettype none

module rfc_apb (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_psel,
    input  wire logic         i_penable,
    input  wire logic         i_pwrite,
    input  wire logic [2:0]   i_paddr,
    input  wire logic [31:0]  i_pwdata,
    output logic [31:0]       o_prdata,
    output rfc_pkg::t_cfg     o_cfg
);

    logic [7:0] r_sync;
    logic [7:0] n_sync;
    logic       wr_sync;

    // write decode, pready is tied high so access completes at once
    always_comb begin
        wr_sync = i_psel && i_penable && i_pwrite && (i_paddr[2] == rfc_pkg::REG_SYNC);
        n_sync  = wr_sync ? i_pwdata[7:0] : r_sync;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= 8'h00;
        end else begin
            r_sync <= n_sync;
        end
    end

    // readback
    always_comb begin
        o_prdata = (i_paddr[2] == rfc_pkg::REG_SYNC) ? {24'h000000, r_sync} : 32'h00000000;
        o_cfg.sync_byte = r_sync;
    end

endmodule

`default_nettype wire

>>> rtl/rfc_framer.sv
// item register, byte sequencer, running crc and output register
`default_nettype none

module rfc_framer (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  rfc_pkg::t_cfg     i_cfg,
    input  wire logic         i_s_valid,
    output logic              o_s_ready,
    input  wire logic [7:0]   i_topic,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_first_byte,
    input  wire logic         i_last_byte,
    output logic              o_m_valid,
    input  wire logic         i_m_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_frame_end
);

    // held item
    logic              r_item_valid, n_item_valid;
    logic [7:0]        r_topic;
    logic [7:0]        r_data;
    logic              r_last;
    rfc_pkg::t_phase_e r_phase, n_phase;
    logic              r_in_record, n_in_record;
    logic [15:0]       r_crc, n_crc;

    // output stage
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_end;

    logic              advance;
    logic              done;
    logic              accept;
    logic              keep;
    logic [7:0]        emit_byte;
    logic [15:0]       crc_base;
    logic              crc_upd;
    rfc_pkg::t_phase_e step_phase;

    // handshake and sequencing control
    always_comb begin
        advance   = r_item_valid && (!r_out_valid || i_m_ready);
        done      = advance && (((r_phase == rfc_pkg::PH_DATA) && !r_last) ||
                                (r_phase == rfc_pkg::PH_CRC_HI));
        o_s_ready = !r_item_valid || done;
        accept    = i_s_valid && o_s_ready;
        keep      = i_first_byte || r_in_record;
    end

    // byte selection and next slot
    always_comb begin
        emit_byte  = r_data;
        crc_upd    = 1'b0;
        step_phase = r_phase;
        unique case (r_phase)
            rfc_pkg::PH_SYNC: begin
                emit_byte  = i_cfg.sync_byte;
                crc_upd    = 1'b1;
                step_phase = rfc_pkg::PH_TOPIC;
            end
            rfc_pkg::PH_TOPIC: begin
                emit_byte  = r_topic;
                crc_upd    = 1'b1;
                step_phase = rfc_pkg::PH_DATA;
            end
            rfc_pkg::PH_DATA: begin
                emit_byte  = r_data;
                crc_upd    = 1'b1;
                step_phase = rfc_pkg::PH_CRC_LO;
            end
            rfc_pkg::PH_CRC_LO: begin
                emit_byte  = r_crc[7:0];
                step_phase = rfc_pkg::PH_CRC_HI;
            end
            rfc_pkg::PH_CRC_HI: begin
                emit_byte  = r_crc[15:8];
                step_phase = rfc_pkg::PH_SYNC;
            end
            default: begin
                emit_byte  = r_data;
                step_phase = rfc_pkg::PH_SYNC;
            end
        endcase
    end

    // running crc, restarted at every sync byte
    always_comb begin
        crc_base = (r_phase == rfc_pkg::PH_SYNC) ? rfc_pkg::CRC_INIT : r_crc;
        n_crc    = (advance && crc_upd) ? rfc_pkg::crc_push(crc_base, emit_byte) : r_crc;
    end

    // next control state
    always_comb begin
        n_item_valid = r_item_valid;
        n_phase      = r_phase;
        if (accept && keep) begin
            n_item_valid = 1'b1;
            n_phase      = i_first_byte ? rfc_pkg::PH_SYNC : rfc_pkg::PH_DATA;
        end else if (done) begin
            n_item_valid = 1'b0;
        end else if (advance) begin
            n_phase      = step_phase;
        end

        n_in_record = r_in_record;
        if (accept) begin
            n_in_record = (i_first_byte || r_in_record) && !i_last_byte;
        end

        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_phase      <= rfc_pkg::PH_SYNC;
            r_in_record  <= 1'b0;
            r_crc        <= rfc_pkg::CRC_INIT;
            r_out_valid  <= 1'b0;
        end else begin
            r_item_valid <= n_item_valid;
            r_phase      <= n_phase;
            r_in_record  <= n_in_record;
            r_crc        <= n_crc;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_topic <= i_topic;
            r_data  <= i_data_byte;
            r_last  <= i_last_byte;
        end
        if (advance) begin
            r_out_byte <= emit_byte;
            r_out_end  <= (r_phase == rfc_pkg::PH_CRC_HI);
        end
    end

    always_comb begin
        o_m_valid   = r_out_valid;
        o_out_byte  = r_out_byte;
        o_frame_end = r_out_end;
    end

endmodule

`default_nettype wire

>>> rtl/record_framer_crc16_top.sv
// top level of the record framer with crc-16 trailer
// datapath: an accepted item is held in the item register, its bytes pass the output register
// throughput: one framed byte per cycle while the output is not stalled; an item frames
// 1 byte, 3 with the first mark, 3 with the last mark, 5 with both, and none outside a record
// reset: synchronous active low; clears sync byte to 0, crc to 0xFFFF, closes any record
`default_nettype none

module record_framer_crc16_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // apb configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input stream
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [15:0]  i_s_axis_tdata,   // [7:0] topic, [15:8] data_byte
    input  wire logic         i_s_axis_tuser,   // [0] first_byte
    input  wire logic         i_s_axis_tlast,   // last_byte
    // output stream
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [7:0]        o_m_axis_tdata,   // [7:0] out_byte
    output logic              o_m_axis_tlast    // frame_end
);

    rfc_pkg::t_cfg cfg;

    assign pready = 1'b1;

    rfc_apb u_apb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    rfc_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_s_valid    (i_s_axis_tvalid),
        .o_s_ready    (o_s_axis_tready),
        .i_topic      (i_s_axis_tdata[7:0]),
        .i_data_byte  (i_s_axis_tdata[15:8]),
        .i_first_byte (i_s_axis_tuser),
        .i_last_byte  (i_s_axis_tlast),
        .o_m_valid    (o_m_axis_tvalid),
        .i_m_ready    (i_m_axis_tready),
        .o_out_byte   (o_m_axis_tdata),
        .o_frame_end  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/rfc_checker.sv
// port-level checks for the record framer and their binding
`default_nettype none

module rfc_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         psel,
    input wire logic         penable,
    input wire logic         pwrite,
    input wire logic [2:0]   paddr,
    input wire logic [31:0]  pwdata,
    input wire logic [31:0]  prdata,
    input wire logic         pready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [7:0]   o_m_axis_tdata,
    input wire logic         o_m_axis_tlast
);

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // stalled output item holds its byte and end mark
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output item changed");

    // sync byte write is visible on readback
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2] |->
            prdata == {24'h000000, $past(pwdata[7:0])})
        else $error("sync byte readback mismatch");

    // accesses never wait
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("pready low during access");

endmodule

bind record_framer_crc16_top rfc_checker u_rfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

>>> sim/tb.sv
// testbench for the record framer: directed table then random records against a predictor
`timescale 1ns / 1ps

module tb;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          RANDOM_ITEMS = 420;
    localparam int          MAX_REPORTS  = 50;
    localparam logic [2:0]  SYNC_ADDR    = {rfc_pkg::REG_SYNC, 2'b00};

    // one byte of the framed stream
    typedef struct packed {
        logic [7:0] value;
        logic       frame_end;
    } t_frame_byte;

    typedef enum logic {ROW_ITEM, ROW_SYNC} t_row_kind;

    // directed row: an item, or a sync byte write (value in data)
    typedef struct packed {
        t_row_kind         kind;
        logic [7:0]        topic;
        logic [7:0]        data;
        logic              first;
        logic              last;
        logic              typed;
        logic [1:0]        n_typed;
        logic [0:2][7:0]   exp_bytes;
    } t_dir_row;

    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_PULSE} t_sink_mode;

    localparam t_dir_row DIR_ROWS [0:21] = '{
        // bytes outside a record are dropped
        '{ROW_ITEM, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 2'd0, '{8'h00, 8'h00, 8'h00}},
        // single-byte record with reset sync byte
        '{ROW_ITEM, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b1, 2'd3, '{8'h00, 8'hFF, 8'h00}},
        '{ROW_ITEM, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b1, 2'd1, '{8'hFF, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'h12, 8'h80, 1'b0, 1'b1, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'h34, 8'h01, 1'b0, 1'b0, 1'b1, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_SYNC, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'h5A, 8'hA5, 1'b1, 1'b0, 1'b1, 2'd3, '{8'hFF, 8'h5A, 8'hA5}},
        '{ROW_ITEM, 8'hC3, 8'h3C, 1'b0, 1'b0, 1'b1, 2'd1, '{8'h3C, 8'h00, 8'h00}},
        // first mark inside an open record restarts it
        '{ROW_ITEM, 8'h01, 8'h02, 1'b1, 1'b0, 1'b1, 2'd3, '{8'hFF, 8'h01, 8'h02}},
        '{ROW_ITEM, 8'h00, 8'h7F, 1'b0, 1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'hAA, 8'h55, 1'b0, 1'b1, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_SYNC, 8'h00, 8'h7E, 1'b0, 1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'h7F, 8'hFE, 1'b1, 1'b1, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'h10, 8'h20, 1'b1, 1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{ROW_ITEM, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}}
    };

    logic         i_clk           = 1'b0;
    logic         i_rst_n         = 1'b0;
    logic         psel            = 1'b0;
    logic         penable         = 1'b0;
    logic         pwrite          = 1'b0;
    logic [2:0]   paddr           = '0;
    logic [31:0]  pwdata          = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [15:0]  i_s_axis_tdata  = '0;    // [7:0] topic, [15:8] data_byte
    logic         i_s_axis_tuser  = 1'b0;  // [0] first_byte
    logic         i_s_axis_tlast  = 1'b0;  // last_byte
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [7:0]   o_m_axis_tdata;          // [7:0] out_byte
    logic         o_m_axis_tlast;          // frame_end

    // framer model state
    logic [7:0]   sync_model = 8'h00;
    logic [15:0]  crc_model  = rfc_pkg::CRC_INIT;
    logic         open_model = 1'b0;

    t_frame_byte  framed_bytes_q[$];
    t_frame_byte  step_bytes[$];
    int           errors       = 0;
    int           cycle_count  = 0;
    int           burst_left   = 0;
    int           items_framed = 0;
    t_sink_mode   sink_mode    = SINK_OPEN;
    int           sink_left    = 0;

    record_framer_crc16_top u_top (.*);

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver backpressure, switching between patterns
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            sink_left <= $urandom_range(20, 200);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            SINK_OPEN:  i_m_axis_tready <= 1'b1;
            SINK_COIN:  i_m_axis_tready <= 1'($urandom_range(0, 1));
            SINK_SLOW:  i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:    i_m_axis_tready <= cycle_count[2];
        endcase
    end

    // compare each output item with the oldest expected byte
    always @(posedge i_clk) begin : check_output
        t_frame_byte want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (framed_bytes_q.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected item out_byte %02h frame_end %0b, none pending",
                             $time, o_m_axis_tdata, o_m_axis_tlast);
                errors++;
            end else begin
                want = framed_bytes_q.pop_front();
                if (o_m_axis_tdata !== want.value) begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.value, o_m_axis_tdata);
                    errors++;
                end
                if (o_m_axis_tlast !== want.frame_end) begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, want.frame_end, o_m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // crc-16 ccitt-false, one byte shifted in msb first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ rfc_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    // framed bytes caused by one payload item, left in step_bytes
    task automatic frame_record_byte(input logic [7:0] topic, input logic [7:0] data,
                                     input logic first, input logic last);
        step_bytes.delete();
        if (first) begin
            open_model = 1'b1;
            step_bytes.push_back('{sync_model, 1'b0});
            step_bytes.push_back('{topic, 1'b0});
            crc_model = crc16_step(crc16_step(rfc_pkg::CRC_INIT, sync_model), topic);
        end
        if (open_model) begin
            step_bytes.push_back('{data, 1'b0});
            crc_model = crc16_step(crc_model, data);
            if (last) begin
                step_bytes.push_back('{crc_model[7:0], 1'b0});
                step_bytes.push_back('{crc_model[15:8], 1'b1});
                crc_model  = rfc_pkg::CRC_INIT;
                open_model = 1'b0;
            end
        end
    endtask

    // sender bursts with random gaps, some bursts back to back
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
    endtask

    // offer one item, record expectations at its accept edge
    task automatic send_item(input logic [7:0] topic, input logic [7:0] data,
                             input logic first, input logic last, input logic typed,
                             input logic [1:0] n_typed, input logic [0:2][7:0] typed_bytes);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {data, topic};
        i_s_axis_tuser  <= first;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        frame_record_byte(topic, data, first, last);
        if (typed) begin
            for (int k = 0; k < n_typed; k++) begin
                framed_bytes_q.push_back('{typed_bytes[k], 1'b0});
            end
        end else begin
            foreach (step_bytes[k]) framed_bytes_q.push_back(step_bytes[k]);
        end
    endtask

    // write the sync byte once the framer is idle, then read it back
    task automatic write_sync(input logic [7:0] value);
        logic [31:0] word;
        word = ($urandom() & 32'hFFFF_FF00) | {24'd0, value};
        i_s_axis_tvalid <= 1'b0;
        while (framed_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SYNC_ADDR;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sync_model = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[7:0] !== value) begin
            $display("%0t: sync_byte readback expected %02h actual %02h",
                     $time, value, prdata[7:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one record of random payload, closed or left open
    task automatic send_record(input int len, input logic close);
        for (int k = 0; k < len; k++) begin
            pace_sender();
            send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), k == 0,
                      close && (k == len - 1), 1'b0, 2'd0, '0);
            if (step_bytes.size() != 0) items_framed++;
        end
    endtask

    // stimulus
    initial begin : stimulus
        int choice;
        int len;
        int next_cfg_at;
        int sync_pick;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (DIR_ROWS[r]) begin
            if (DIR_ROWS[r].kind == ROW_SYNC) begin
                write_sync(DIR_ROWS[r].data);
            end else begin
                pace_sender();
                send_item(DIR_ROWS[r].topic, DIR_ROWS[r].data, DIR_ROWS[r].first,
                          DIR_ROWS[r].last, DIR_ROWS[r].typed, DIR_ROWS[r].n_typed,
                          DIR_ROWS[r].exp_bytes);
            end
        end

        // random records, mostly well formed, some noise and abandoned ones
        next_cfg_at = 0;
        sync_pick   = 0;
        while (items_framed < RANDOM_ITEMS) begin
            if (items_framed >= next_cfg_at) begin
                case (sync_pick)
                    0:       write_sync(8'h00);
                    1:       write_sync(8'hFF);
                    default: write_sync(8'($urandom_range(0, 255)));
                endcase
                sync_pick++;
                next_cfg_at += 90;
            end
            choice = $urandom_range(0, 99);
            if (choice < 8) begin
                pace_sender();
                send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
                          1'($urandom_range(0, 1)), 1'b0, 2'd0, '0);
                if (step_bytes.size() != 0) items_framed++;
            end else begin
                if (choice < 70)      len = $urandom_range(1, 4);
                else if (choice < 92) len = $urandom_range(5, 12);
                else                  len = $urandom_range(13, 40);
                send_record(len, choice >= 16);
            end
        end

        // drain
        i_s_axis_tvalid <= 1'b0;
        while (framed_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> record_framer_crc16_top.f
rtl/rfc_pkg.sv
rtl/rfc_apb.sv
rtl/rfc_framer.sv
rtl/record_framer_crc16_top.sv
rtl/rfc_checker.sv
sim/tb.sv
